// ===== rtl/core/cwd_pkg.sv =====
// shared types and constants for the convergence window detector
// no dependencies; imported by every module under rtl/core except cwd_ram
package cwd_pkg;

    // default ring depth and register reset values
    localparam int MAX_HISTORY_DEF = 64;
    localparam logic [6:0] HIST_LEN_RESET = 7'd16;
    localparam logic [15:0] THRESHOLD_RESET = 16'd655;

    // configuration port widths and register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd1;

    // item operations
    localparam logic OP_VALUE = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // one tracked item handed from the tracker to the compare stage
    typedef struct packed {
        logic signed [31:0] cur;     // newest generation best, zero if none yet
        logic               full;    // window holds enough generations
        logic               err;     // advance with no value
        logic               fwd;     // reference slot written by this same item
        logic signed [31:0] fwd_val; // value written to the ring by this item
    } cwd_item_t;

endpackage

// ===== rtl/core/cwd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module cwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/cwd_tracker.sv =====
// generation tracking: slot pointer, generation count, current best and ring access
// depends on cwd_pkg
module cwd_tracker #(
    parameter int MAX_HISTORY = cwd_pkg::MAX_HISTORY_DEF,
    localparam int IDX_W = $clog2(MAX_HISTORY)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               operation,
    input  logic signed [31:0] value,
    input  logic               restart,
    input  logic [6:0]         history_length,
    output logic               ram_wr_en,
    output logic [IDX_W-1:0]   ram_wr_addr,
    output logic [31:0]        ram_wr_data,
    output logic               ram_rd_en,
    output logic [IDX_W-1:0]   ram_rd_addr,
    output cwd_pkg::cwd_item_t item
);

    import cwd_pkg::*;

    localparam int N_W = $clog2(MAX_HISTORY + 1);
    localparam int CNT_W = $clog2(MAX_HISTORY + 2);

    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   gen_cnt_reg, gen_cnt_next;
    logic               awaiting_reg, awaiting_next;
    logic signed [31:0] best_reg, best_next;

    logic [N_W-1:0]     win_len;
    logic [N_W-1:0]     slot_inc;
    logic [IDX_W-1:0]   slot_succ;
    logic               write_slot;
    logic               adv_err;

    // window length in use, at least one and clamped to the ring depth
    always_comb
    begin
        if (history_length == 7'd0)
        begin
            win_len = N_W'(1);
        end
        else if (int'(history_length) > MAX_HISTORY)
        begin
            win_len = N_W'(MAX_HISTORY);
        end
        else
        begin
            win_len = N_W'(history_length);
        end
    end

    // following slot with wrap at the window length
    always_comb
    begin
        slot_inc = N_W'(slot_reg) + N_W'(1);
        slot_succ = (slot_inc >= win_len) ? '0 : slot_inc[IDX_W-1:0];
    end

    // next state and ring access for the item on the input
    always_comb
    begin
        slot_next = slot_reg;
        gen_cnt_next = gen_cnt_reg;
        awaiting_next = awaiting_reg;
        best_next = best_reg;
        write_slot = 1'b0;
        adv_err = 1'b0;
        ram_rd_addr = slot_succ;

        case (operation)
            OP_VALUE:
            begin
                write_slot = 1'b1;
                awaiting_next = 1'b0;
                if (awaiting_reg)
                begin
                    best_next = value;
                    if (gen_cnt_reg < CNT_W'(MAX_HISTORY + 1))
                    begin
                        gen_cnt_next = gen_cnt_reg + CNT_W'(1);
                    end
                end
                else if (value < best_reg)
                begin
                    best_next = value;
                end
            end
            OP_ADVANCE:
            begin
                if (awaiting_reg)
                begin
                    // nothing submitted: oldest is the slot about to be written
                    adv_err = 1'b1;
                    ram_rd_addr = slot_reg;
                end
                else
                begin
                    slot_next = slot_succ;
                    awaiting_next = 1'b1;
                end
            end
            default:
            begin
                adv_err = 1'b0;
            end
        endcase
    end

    assign ram_wr_en = accept && write_slot;
    assign ram_wr_addr = slot_reg;
    assign ram_wr_data = best_next;
    assign ram_rd_en = accept;

    // item summary for the compare stage
    always_comb
    begin
        item.cur = (gen_cnt_next != '0) ? best_next : 32'sd0;
        item.full = (gen_cnt_next >= (CNT_W'(win_len) + CNT_W'(1)));
        item.err = adv_err;
        item.fwd = write_slot && (ram_rd_addr == slot_reg);
        item.fwd_val = best_next;
    end

    // tracking state, restarted by a history length write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            gen_cnt_reg <= '0;
            awaiting_reg <= 1'b1;
        end
        else if (restart)
        begin
            slot_reg <= '0;
            gen_cnt_reg <= '0;
            awaiting_reg <= 1'b1;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
            gen_cnt_reg <= gen_cnt_next;
            awaiting_reg <= awaiting_next;
        end
    end

    // current best, meaningful once a value has been taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            best_reg <= best_next;
        end
    end

endmodule

// ===== rtl/core/cwd_judge.sv =====
// compare stage: relative difference test and output register
// depends on cwd_pkg
module cwd_judge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cwd_pkg::cwd_item_t item,
    input  logic [31:0]        rd_data,
    input  logic [15:0]        threshold,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               finished,
    output logic               advance_error,
    output logic signed [31:0] current_best,
    output logic signed [31:0] reference_best
);

    import cwd_pkg::*;

    logic               s1_valid_reg;
    cwd_item_t          s1_item_reg;
    logic               s1_move;

    logic signed [31:0] ref_val;
    logic [32:0]        delta;
    logic [32:0]        diff;
    logic [31:0]        mag;
    logic [48:0]        lhs;
    logic [47:0]        rhs;
    logic               fin;

    logic               out_valid_reg;
    logic               finished_reg;
    logic               advance_error_reg;
    logic signed [31:0] current_best_reg;
    logic signed [31:0] reference_best_reg;

    // stage flow: the compare stage empties into the output register
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign ready = !s1_valid_reg || s1_move;

    // reference is zero until the window is full, else from the ring, or the value this item wrote
    always_comb
    begin
        if (!s1_item_reg.full)
        begin
            ref_val = 32'sd0;
        end
        else if (s1_item_reg.fwd)
        begin
            ref_val = s1_item_reg.fwd_val;
        end
        else
        begin
            ref_val = rd_data;
        end
    end

    // |cur - ref| < thr * |ref| with thr in Q0.16, or cur equal to ref
    always_comb
    begin
        delta = {s1_item_reg.cur[31], s1_item_reg.cur} - {ref_val[31], ref_val};
        diff = delta[32] ? (~delta + 33'd1) : delta;
        mag = ref_val[31] ? (~ref_val + 32'd1) : ref_val;
        lhs = {diff, 16'd0};
        rhs = 48'(threshold) * 48'(mag);
        fin = s1_item_reg.full && ((diff == 33'd0) || (lhs < 49'(rhs)));
    end

    // compare stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg <= item;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            finished_reg <= fin;
            advance_error_reg <= s1_item_reg.err;
            current_best_reg <= s1_item_reg.cur;
            reference_best_reg <= ref_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign finished = finished_reg;
    assign advance_error = advance_error_reg;
    assign current_best = current_best_reg;
    assign reference_best = reference_best_reg;

endmodule

// ===== rtl/core/convergence_window_detector.sv =====
// top level of the convergence window detector
// depends on cwd_pkg, cwd_tracker, cwd_ram and cwd_judge
//
// Input channel (in_valid/in_ready) carries operation and value: a value
// transfer sets or lowers the best of the current generation, an advance transfer
// closes it. Every input transfer gives exactly one result transfer on the
// output channel (out_valid/out_ready) with finished, advance_error,
// current_best and reference_best.
// The compare stage takes the item at the input transfer edge and the output
// register takes the result from it whenever the output register is free.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single-port ring read for the reference slot and one 16x32 multiply
// in the compare stage.
// When the receiver stalls, the output register holds its result and the
// compare stage keeps one more item; in_ready drops only once both are full.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 sets history_length and restarts tracking, index 1 sets the
// threshold, other indexes are ignored. Write it only while idle.
// Reset clears both pipeline stages, the slot pointer and generation count,
// and loads history_length 16 and threshold 655. The ring needs no clearing:
// a slot is only read as reference after it has been written.
module convergence_window_detector #(
    parameter int MAX_HISTORY = cwd_pkg::MAX_HISTORY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic signed [31:0]              value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            finished,
    output logic                            advance_error,
    output logic signed [31:0]              current_best,
    output logic signed [31:0]              reference_best,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cwd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import cwd_pkg::*;

    localparam int IDX_W = $clog2(MAX_HISTORY);

    logic             in_accept;
    logic             cfg_accept;
    logic             restart;
    logic [6:0]       hist_len_reg;
    logic [15:0]      threshold_reg;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [31:0]      ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [31:0]      ram_rd_data;
    cwd_item_t        item;

    assign cfg_ready = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign restart = cfg_accept && (cfg_index == REG_HISTORY_LENGTH);
    assign in_accept = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_len_reg <= HIST_LEN_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_HISTORY_LENGTH: hist_len_reg <= cfg_data[6:0];
                REG_THRESHOLD:      threshold_reg <= cfg_data;
                default:            hist_len_reg <= hist_len_reg;
            endcase
        end
    end

    // generation tracking
    cwd_tracker #(
        .MAX_HISTORY (MAX_HISTORY)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .operation      (operation),
        .value          (value),
        .restart        (restart),
        .history_length (hist_len_reg),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .item           (item)
    );

    // history ring
    cwd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_HISTORY)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // convergence test and result register
    cwd_judge u_judge (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_accept),
        .item           (item),
        .rd_data        (ram_rd_data),
        .threshold      (threshold_reg),
        .ready          (in_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .finished       (finished),
        .advance_error  (advance_error),
        .current_best   (current_best),
        .reference_best (reference_best)
    );

    // an error is only ever raised by an advance
    a_err_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && item.err |-> operation == OP_ADVANCE)
        else $error("advance error flagged on a value transfer");

    // input only stalls when the output register is occupied
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output register");

    // a zero reference can only be reported as converged against zero
    a_zero_ref_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished && reference_best == 32'sd0 |-> current_best == 32'sd0)
        else $error("finished against zero reference with nonzero current");

    // a value transfer never produces an advance error result
    a_value_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && operation == OP_VALUE |=> !item.err || in_accept)
        else $error("error flag on value path");

endmodule
